[hdl/wis_pkg.sv]
// package: request types, interval record and shared constants for weighted interval scheduling
package wis_pkg;

    localparam int MAX_INTERVALS_DEF = 64;
    localparam int TIME_W            = 16;
    localparam int END_W             = 17;
    localparam int PRICE_W           = 16;
    localparam int BEST_TOTAL_W      = 22;

    typedef struct packed {
        logic [TIME_W-1:0]  start_time;
        logic [TIME_W-1:0]  duration;
        logic [PRICE_W-1:0] price;
        logic               is_last;
    } t_in_req;

    typedef struct packed {
        logic [BEST_TOTAL_W-1:0] best_total;
        logic                    overflow;
    } t_out_req;

    typedef struct packed {
        logic [END_W-1:0]   end_t;
        logic [TIME_W-1:0]  start_t;
        logic [PRICE_W-1:0] price;
    } t_ival;

    typedef struct packed {
        logic ins;
        logic drain;
    } t_cell_ctl;

endpackage

[hdl/wis_cell.sv]
// one cell of the sorting chain: holds one interval, inserts by end then start, shifts out on drain
module wis_cell (
    input  logic              i_clk,
    input  wis_pkg::t_cell_ctl i_ctl,
    input  logic              i_valid,
    input  logic              i_at_count,
    input  wis_pkg::t_ival    i_new,
    input  wis_pkg::t_ival    i_prev,
    input  logic              i_prev_gt,
    input  wis_pkg::t_ival    i_next,
    output wis_pkg::t_ival    o_data,
    output logic              o_gt
);
    import wis_pkg::*;

    t_ival r_data;

    // held interval sorts after the incoming one
    assign o_gt   = i_valid && ({r_data.end_t, r_data.start_t} > {i_new.end_t, i_new.start_t});
    assign o_data = r_data;

    always_ff @(posedge i_clk) begin
        if (i_ctl.drain) begin
            r_data <= i_next;
        end else if (i_ctl.ins) begin
            if (i_prev_gt) begin
                r_data <= i_prev;
            end else if (o_gt || i_at_count) begin
                r_data <= i_new;
            end
        end
    end

endmodule

[hdl/weighted_interval_scheduling_top.sv]
// requests are taken only in the load state; after the last one, draining fills the sorted memories,
// then each interval runs fetch, a search/compare binary search over the end memory, and calc.
// throughput: one set computed at a time; the next set loads while a result request waits,
// and the last calc step of that set holds until the output register is free.
// the insertion chain sorts while loading, the single end memory read port sets the search pace.
// reset (synchronous, active low) empties the set and clears the overflow flag; no clearing pass.
module weighted_interval_scheduling_top #(
    parameter int MAX_INTERVALS = wis_pkg::MAX_INTERVALS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  wis_pkg::t_in_req  i_in_req,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output wis_pkg::t_out_req o_out_req
);
    import wis_pkg::*;

    localparam int IW = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
    localparam int CW = $clog2(MAX_INTERVALS + 1);
    localparam int BW = PRICE_W + $clog2(MAX_INTERVALS) + 1;

    typedef enum logic [5:0] {
        S_LOAD  = 6'b000001,
        S_DRAIN = 6'b000010,
        S_FETCH = 6'b000100,
        S_SRCH  = 6'b001000,
        S_CMP   = 6'b010000,
        S_CALC  = 6'b100000
    } t_state;

    t_state          r_state;
    logic [CW-1:0]   r_count;
    logic            r_ovf;
    logic [IW-1:0]   r_d;
    logic [IW-1:0]   r_i;
    logic [IW-1:0]   r_lo;
    logic [IW-1:0]   r_hi;
    logic [BW-1:0]   r_prev;
    logic            r_out_valid;
    logic [BEST_TOTAL_W-1:0] r_out_total;
    logic            r_out_ovf;

    logic [TIME_W-1:0]  start_mem [MAX_INTERVALS];
    logic [END_W-1:0]   end_mem   [MAX_INTERVALS];
    logic [PRICE_W-1:0] price_mem [MAX_INTERVALS];
    logic [BW-1:0]      best_mem  [MAX_INTERVALS];
    logic [TIME_W-1:0]  r_st_rd;
    logic [PRICE_W-1:0] r_pr_rd;
    logic [END_W-1:0]   r_end_rd;
    logic [BW-1:0]      r_best_rd;

    logic          w_accept;
    logic          w_room;
    logic          w_out_free;
    logic          w_out_load;
    logic [IW-1:0] w_mid;
    logic [IW-1:0] w_last_idx;
    logic [BW-1:0] w_take;
    logic [BW-1:0] w_skip;
    logic [BW-1:0] w_best;
    t_ival         w_new;
    t_cell_ctl     w_ctl;
    t_ival         w_data [MAX_INTERVALS];
    logic          w_gt   [MAX_INTERVALS];

    assign o_in_ready  = (r_state == S_LOAD);
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_room      = r_count < CW'(MAX_INTERVALS);
    assign w_mid       = r_lo + ((r_hi - r_lo) >> 1);
    assign w_last_idx  = IW'(r_count - CW'(1));
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign w_out_load  = (r_state == S_CALC) && (r_i == w_last_idx) && w_out_free;

    assign w_new.start_t = i_in_req.start_time;
    assign w_new.end_t   = END_W'(i_in_req.start_time) + END_W'(i_in_req.duration);
    assign w_new.price   = i_in_req.price;

    assign w_ctl.ins   = w_accept && w_room;
    assign w_ctl.drain = (r_state == S_DRAIN);

    genvar k;
    generate
        for (k = 0; k < MAX_INTERVALS; k++) begin : g_cell
            wis_cell u_cell (
                .i_clk      (i_clk),
                .i_ctl      (w_ctl),
                .i_valid    (CW'(k) < r_count),
                .i_at_count (CW'(k) == r_count),
                .i_new      (w_new),
                .i_prev     ((k == 0) ? w_new : w_data[(k == 0) ? 0 : k-1]),
                .i_prev_gt  ((k == 0) ? 1'b0 : w_gt[(k == 0) ? 0 : k-1]),
                .i_next     ((k == MAX_INTERVALS-1) ? w_data[k]
                                                     : w_data[(k == MAX_INTERVALS-1) ? k : k+1]),
                .o_data     (w_data[k]),
                .o_gt       (w_gt[k])
            );
        end
    endgenerate

    assign w_take = BW'(r_pr_rd) + ((r_lo != '0) ? r_best_rd : '0);
    assign w_skip = (r_i == '0) ? '0 : r_prev;
    assign w_best = (w_take > w_skip) ? w_take : w_skip;

    // sorted memories, filled from the head of the chain
    always_ff @(posedge i_clk) begin
        if (r_state == S_DRAIN) begin
            start_mem[r_d] <= w_data[0].start_t;
            end_mem[r_d]   <= w_data[0].end_t;
            price_mem[r_d] <= w_data[0].price;
        end
        if (r_state == S_CALC) begin
            best_mem[r_i] <= w_best;
        end
        r_st_rd   <= start_mem[r_i];
        r_pr_rd   <= price_mem[r_i];
        r_end_rd  <= end_mem[w_mid];
        r_best_rd <= best_mem[r_lo - IW'(1)];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_d         <= '0;
            r_i         <= '0;
            r_lo        <= '0;
            r_hi        <= '0;
        end else begin
            unique case (r_state)
                S_LOAD: begin
                    if (w_accept) begin
                        if (w_room) begin
                            r_count <= r_count + CW'(1);
                        end else begin
                            r_ovf <= 1'b1;
                        end
                        if (i_in_req.is_last) begin
                            r_d     <= '0;
                            r_state <= S_DRAIN;
                        end
                    end
                end
                S_DRAIN: begin
                    r_d <= r_d + IW'(1);
                    if (r_d == w_last_idx) begin
                        r_i     <= '0;
                        r_state <= S_FETCH;
                    end
                end
                S_FETCH: begin
                    r_lo    <= '0;
                    r_hi    <= r_i;
                    r_state <= S_SRCH;
                end
                S_SRCH: begin
                    r_state <= (r_lo < r_hi) ? S_CMP : S_CALC;
                end
                S_CMP: begin
                    if (r_end_rd <= END_W'(r_st_rd)) begin
                        r_lo <= w_mid + IW'(1);
                    end else begin
                        r_hi <= w_mid;
                    end
                    r_state <= S_SRCH;
                end
                S_CALC: begin
                    if (r_i != w_last_idx) begin
                        r_prev  <= w_best;
                        r_i     <= r_i + IW'(1);
                        r_state <= S_FETCH;
                    end else if (w_out_free) begin
                        // result moves to the output register, the set is emptied
                        r_count <= '0;
                        r_ovf   <= 1'b0;
                        r_state <= S_LOAD;
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_total <= BEST_TOTAL_W'(w_best);
            r_out_ovf   <= r_ovf;
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_out_req.best_total = r_out_total;
    assign o_out_req.overflow   = r_out_ovf;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_INTERVALS)) else $error("count beyond capacity");
    a_clear_after_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_load |=> r_count == '0 && !r_ovf) else $error("set not cleared");
    a_search_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CMP |-> r_lo < r_hi) else $error("search bounds crossed");
    a_no_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_LOAD |-> !o_in_ready) else $error("request taken while busy");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_req))
        else $error("result request changed while waiting");

endmodule

[tb/sv/weighted_interval_scheduling_top_test.sv]
// testbench: interval sets against a scheduling predictor, with random idling and back-pressure
`timescale 1ns / 1ps

module weighted_interval_scheduling_top_test;
    import wis_pkg::*;

    localparam int CAP        = MAX_INTERVALS_DEF;
    localparam int STALL_LIMIT = 20000;

    logic     i_clk = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     i_in_valid = 1'b0;
    logic     o_in_ready;
    t_in_req  i_in_req = '0;
    logic     o_out_valid;
    logic     i_out_ready = 1'b0;
    t_out_req o_out_req;

    weighted_interval_scheduling_top i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_req(i_in_req),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_req(o_out_req)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor state: the intervals of the set being loaded
    logic [16:0] set_end   [CAP];
    logic [15:0] set_start [CAP];
    logic [15:0] set_price [CAP];
    int          set_count = 0;
    bit          set_overflow = 0;
    t_out_req    totals_due [$];

    int  errors = 0;
    int  sent = 0;
    int  totals_seen = 0;
    int  overflow_sets = 0;
    bit  no_idle = 0;
    bit  hold_out = 0;
    int  quiet = 0;

    function automatic logic [21:0] best_schedule(int n);
        logic [16:0] e [CAP];
        logic [15:0] s [CAP];
        logic [15:0] p [CAP];
        logic [22:0] tab [CAP];
        logic [16:0] te;
        logic [15:0] ts;
        logic [15:0] tp;
        logic [22:0] take;
        int k, lo, hi, mid;
        if (n == 0) return '0;
        for (int i = 0; i < n; i++) begin
            e[i] = set_end[i]; s[i] = set_start[i]; p[i] = set_price[i];
        end
        // insertion sort by end, ties by start
        for (int i = 1; i < n; i++) begin
            te = e[i]; ts = s[i]; tp = p[i]; k = i;
            while (k > 0 && (e[k-1] > te || (e[k-1] == te && s[k-1] > ts))) begin
                e[k] = e[k-1]; s[k] = s[k-1]; p[k] = p[k-1]; k--;
            end
            e[k] = te; s[k] = ts; p[k] = tp;
        end
        tab[0] = 23'(p[0]);
        for (int i = 1; i < n; i++) begin
            lo = 0; hi = i;
            while (lo < hi) begin
                mid = lo + (hi - lo) / 2;
                if (e[mid] <= {1'b0, s[i]}) lo = mid + 1;
                else hi = mid;
            end
            take = 23'(p[i]) + (lo > 0 ? tab[lo-1] : 23'd0);
            tab[i] = take > tab[i-1] ? take : tab[i-1];
        end
        return tab[n-1][21:0];
    endfunction

    task automatic absorb_interval(t_in_req r);
        t_out_req t;
        if (set_count < CAP) begin
            set_start[set_count] = r.start_time;
            set_end[set_count]   = {1'b0, r.start_time} + {1'b0, r.duration};
            set_price[set_count] = r.price;
            set_count++;
        end else begin
            set_overflow = 1;
        end
        if (r.is_last) begin
            t.best_total = best_schedule(set_count);
            t.overflow   = set_overflow;
            totals_due.push_back(t);
            set_count = 0;
            set_overflow = 0;
        end
    endtask

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (totals_due.size() == 0) begin
                $display("%0t: unexpected result best_total=%0d overflow=%0b",
                         $time, o_out_req.best_total, o_out_req.overflow);
                errors++;
            end else begin
                if (o_out_req.best_total !== totals_due[0].best_total) begin
                    $display("%0t: best_total expected %0d actual %0d", $time,
                             totals_due[0].best_total, o_out_req.best_total);
                    errors++;
                end
                if (o_out_req.overflow !== totals_due[0].overflow) begin
                    $display("%0t: overflow expected %0b actual %0b", $time,
                             totals_due[0].overflow, o_out_req.overflow);
                    errors++;
                end
                if (totals_due[0].overflow) overflow_sets++;
                void'(totals_due.pop_front());
            end
            totals_seen++;
        end
    end

    // receiver: random idle bursts, optional long hold-off
    initial begin
        int gap;
        @(posedge i_clk);
        while (1) begin
            if (hold_out) begin
                i_out_ready <= 1'b0;
                repeat (3000) @(posedge i_clk);
                hold_out = 0;
            end else if (!no_idle && $urandom_range(0, 3) == 0) begin
                gap = $urandom_range(1, 14);
                i_out_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) quiet <= 0;
        else quiet <= quiet + 1;
        if (quiet >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic send_interval(t_in_req r);
        int gap;
        if (!no_idle && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 14);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_req   <= r;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        absorb_interval(r);
        sent++;
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (totals_due.size() != 0) @(posedge i_clk);
    endtask

    function automatic t_in_req rand_interval(int mode, bit last);
        t_in_req r;
        r.is_last = last;
        case (mode)
            0: begin
                r.start_time = 16'($urandom);
                r.duration   = 16'($urandom);
                r.price      = 16'($urandom);
            end
            1: begin
                // dense small window: many overlaps and equal ends
                r.start_time = 16'($urandom_range(0, 40));
                r.duration   = 16'($urandom_range(0, 8));
                r.price      = 16'($urandom_range(0, 100));
            end
            default: begin
                r.start_time = 16'($urandom_range(65000, 65535));
                r.duration   = $urandom_range(0, 1) ? 16'hFFFF : 16'($urandom_range(0, 600));
                r.price      = $urandom_range(0, 1) ? 16'hFFFF : 16'($urandom);
            end
        endcase
        return r;
    endfunction

    // directed rows: start, duration, price, last, check, expected total, expected overflow
    typedef struct {
        t_in_req  req;
        bit       typed;
        t_out_req want;
    } t_row;

    t_row rows [$];

    task automatic add_row(int st, int du, int pr, bit last, bit typed, int tot, bit ov);
        t_row w;
        w.req.start_time = 16'(st); w.req.duration = 16'(du); w.req.price = 16'(pr);
        w.req.is_last = last;
        w.typed = typed; w.want.best_total = 22'(tot); w.want.overflow = ov;
        rows.push_back(w);
    endtask

    initial begin
        int len, mode;
        t_in_req r;
        // single intervals at the extremes
        add_row(0, 0, 0, 1, 1, 0, 0);
        add_row(16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 1, 65535, 0);
        add_row(0, 16'hFFFF, 16'hFFFF, 1, 1, 65535, 0);
        // two disjoint intervals, maximal prices
        add_row(0, 10, 16'hFFFF, 0, 0, 0, 0);
        add_row(10, 10, 16'hFFFF, 1, 1, 131070, 0);
        // overlap: better one wins
        add_row(0, 10, 5, 0, 0, 0, 0);
        add_row(5, 10, 9, 1, 1, 9, 0);
        // zero-length intervals at a shared end
        add_row(0, 10, 3, 0, 0, 0, 0);
        add_row(10, 0, 4, 0, 0, 0, 0);
        add_row(10, 0, 6, 0, 0, 0, 0);
        add_row(10, 5, 1, 1, 0, 0, 0);
        // no compatible interval, unsorted arrival
        add_row(50, 30, 7, 0, 0, 0, 0);
        add_row(20, 40, 8, 0, 0, 0, 0);
        add_row(0, 90, 2, 1, 0, 0, 0);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i]) begin
            send_interval(rows[i].req);
            if (rows[i].typed && rows[i].req.is_last) begin
                if (totals_due[$] != rows[i].want) begin
                    $display("%0t: table row %0d expected %0d/%0b actual %0d/%0b", $time, i,
                             rows[i].want.best_total, rows[i].want.overflow,
                             totals_due[$].best_total, totals_due[$].overflow);
                    errors++;
                end
            end
        end

        // full store then overflow: 64 unit intervals, extras dropped
        for (int i = 0; i < CAP + 3; i++) begin
            r.start_time = 16'(i); r.duration = 16'd1; r.price = 16'hFFFF;
            r.is_last = (i == CAP + 2);
            send_interval(r);
        end
        if (totals_due[$].best_total != 22'(CAP * 65535) || totals_due[$].overflow != 1'b1) begin
            $display("%0t: overflow set expected %0d/1 actual %0d/%0b", $time, CAP * 65535,
                     totals_due[$].best_total, totals_due[$].overflow);
            errors++;
        end
        // set of exactly capacity, no overflow
        for (int i = 0; i < CAP; i++) send_interval(rand_interval(0, i == CAP - 1));

        // pause until drained, then a long receiver hold-off while sets keep coming
        wait_drained();
        hold_out = 1;
        for (int k = 0; k < 6; k++) begin
            for (int i = 0; i < 3; i++) send_interval(rand_interval(1, i == 2));
        end

        // random sets, mostly small
        while (sent < 1300) begin
            if (sent > 1100) no_idle = 1;
            mode = $urandom_range(0, 2);
            case ($urandom_range(0, 9))
                0:       len = $urandom_range(60, 70);
                1, 2:    len = $urandom_range(10, 30);
                default: len = $urandom_range(1, 8);
            endcase
            for (int i = 0; i < len; i++) send_interval(rand_interval(mode, i == len - 1));
        end

        wait_drained();
        repeat (2000) @(posedge i_clk);
        $display("sent %0d intervals in sets, %0d totals checked, %0d with overflow",
                 sent, totals_seen, overflow_sets);
        if (errors == 0 && totals_due.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

[weighted_interval_scheduling_top.f]
hdl/wis_pkg.sv
hdl/wis_cell.sv
hdl/weighted_interval_scheduling_top.sv
tb/sv/weighted_interval_scheduling_top_test.sv
